// ===== hdl/shs_pkg.sv =====
// shared constants, round constants, initial hash values and sigma functions for the sha-256 hasher
package shs_pkg;

    localparam int HASH_WORDS  = 8;
    localparam int BLOCK_WORDS = 16;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 61;
    localparam int ROUNDS      = 64;
    localparam int HADDR_W     = $clog2(HASH_WORDS);
    localparam int BADDR_W     = $clog2(BLOCK_WORDS);

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t init_word(input logic [HADDR_W-1:0] idx);
        case (idx)
            3'd0: init_word = 32'h6a09e667;
            3'd1: init_word = 32'hbb67ae85;
            3'd2: init_word = 32'h3c6ef372;
            3'd3: init_word = 32'ha54ff53a;
            3'd4: init_word = 32'h510e527f;
            3'd5: init_word = 32'h9b05688c;
            3'd6: init_word = 32'h1f83d9ab;
            default: init_word = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ===== hdl/sha256_stream_hasher_top.sv =====
// top level of the streaming sha-256 hasher
//
//  channel | dir | tdata            | tuser          | tlast
//  s_      | in  | [7:0] data byte  | [0] func       | -
//  m_      | out | [31:0] digest wd | [2:0] word idx | last digest word
//
// data bytes are accepted while idle; the 64th byte of a block starts a compression
// through the load, round and fold states, load and fold paced by the registered reads of
// the hash and block rams
// finish pushes one padding byte per cycle (9 to 72 bytes) apart from one or two compressions,
// then reads each digest word out through the hash ram read port and the output register
// s_tready is low while padding, compressing or reading out the digest; m_ side stalls
// hold the digest read-out; the next message is taken while the last word waits
// reset (aresetn low, synchronous) returns to the initial hash values and a zero count
module sha256_stream_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import shs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_FOLD  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [63:0]          len_reg, len_next;
    logic [23:0]          acc_reg, acc_next;
    logic                 fin_reg, fin_next;      // padding a finished message
    logic                 phase_reg, phase_next;  // marker byte already pushed
    logic                 done_reg, done_next;    // length bytes all pushed
    logic                 tail_reg, tail_next;    // length bytes go in the current block
    logic [HASH_WORDS-1:0] hvalid_reg, hvalid_next;
    logic [6:0]           cnt_reg, cnt_next;
    word_t                w_reg [BLOCK_WORDS];
    word_t                w_next [BLOCK_WORDS];
    word_t                v_reg [HASH_WORDS];
    word_t                v_next [HASH_WORDS];
    logic [HADDR_W-1:0]   hsel_reg;
    logic [HADDR_W-1:0]   oidx_reg, oidx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    word_t                m_data_reg, m_data_next;
    logic [HADDR_W-1:0]   m_idx_reg, m_idx_next;
    logic                 m_last_reg, m_last_next;

    // ram ports
    logic                 bram_we;
    logic [BADDR_W-1:0]   bram_waddr, bram_raddr;
    word_t                bram_wdata, bram_rdata;
    logic                 hram_we;
    logic [HADDR_W-1:0]   hram_waddr, hram_raddr;
    word_t                hram_wdata, hram_rdata;

    // datapath helpers
    logic                 push;
    logic [7:0]           push_byte;
    logic [5:0]           fill;
    word_t                hword;
    word_t                t1, t2, w_new;

    assign fill     = count_reg[5:0];
    assign s_tready = (state_reg == S_IDLE);
    assign hword    = hvalid_reg[hsel_reg] ? hram_rdata : init_word(hsel_reg);

    // round datapath
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(cnt_reg[5:0]) + w_reg[0];
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];

    // byte source: input transaction or padding sequence
    always_comb begin
        push = (state_reg == S_PAD) || ((state_reg == S_IDLE) && s_tvalid && !s_tuser);
        if (state_reg != S_PAD) begin
            push_byte = s_tdata;
        end else if (!phase_reg) begin
            push_byte = PAD_BYTE;
        end else if (tail_reg && (fill >= LEN_START)) begin
            push_byte = len_reg[{~fill[2:0], 3'b000} +: 8];
        end else begin
            push_byte = 8'h00;
        end
    end

    assign bram_we    = push && (fill[1:0] == 2'b11);
    assign bram_waddr = fill[5:2];
    assign bram_wdata = {acc_reg, push_byte};
    assign bram_raddr = cnt_reg[BADDR_W-1:0];

    always_comb begin
        hram_raddr = (state_reg == S_OUT) ? oidx_reg : cnt_reg[HADDR_W-1:0];
        hram_we    = (state_reg == S_FOLD) && (cnt_reg != 7'd0);
        hram_waddr = hsel_reg;
        hram_wdata = hword + v_reg[0];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        acc_next      = acc_reg;
        fin_next      = fin_reg;
        phase_next    = phase_reg;
        done_next     = done_reg;
        tail_next     = tail_reg;
        hvalid_next   = hvalid_reg;
        cnt_next      = cnt_reg;
        w_next        = w_reg;
        v_next        = v_reg;
        oidx_next     = oidx_reg;
        rd_pend_next  = rd_pend_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_idx_next    = m_idx_reg;
        m_last_next   = m_last_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // byte append, shared by data transactions and padding
        if (push) begin
            acc_next   = {acc_reg[15:0], push_byte};
            count_next = count_reg + COUNT_W'(1);
            if (state_reg == S_PAD) begin
                phase_next = 1'b1;
                if (phase_reg && tail_reg && (fill == BLOCK_LAST)) begin
                    done_next = 1'b1;
                end
                // padding spilled over, the length goes in the next block
                if (fill == BLOCK_LAST) begin
                    tail_next = 1'b1;
                end
            end
            if (fill == BLOCK_LAST) begin
                state_next = S_LOAD;
                cnt_next   = 7'd0;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tuser) begin
                    len_next   = {count_reg, 3'b000};
                    fin_next   = 1'b1;
                    phase_next = 1'b0;
                    done_next  = 1'b0;
                    tail_next  = (fill < LEN_START);
                    state_next = S_PAD;
                end
            end
            S_PAD: begin
            end
            S_LOAD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0) begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                        w_next[i] = w_reg[i+1];
                    end
                    w_next[BLOCK_WORDS-1] = bram_rdata;
                end
                if ((cnt_reg != 7'd0) && (cnt_reg <= 7'(HASH_WORDS))) begin
                    for (int i = 0; i < HASH_WORDS - 1; i++) begin
                        v_next[i] = v_reg[i+1];
                    end
                    v_next[HASH_WORDS-1] = hword;
                end
                if (cnt_reg == 7'(BLOCK_WORDS)) begin
                    cnt_next   = 7'd0;
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                cnt_next  = cnt_reg + 7'd1;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[BLOCK_WORDS-1] = w_new;
                if (cnt_reg == 7'(ROUNDS - 1)) begin
                    cnt_next   = 7'd0;
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != 7'd0) begin
                    hvalid_next[hsel_reg] = 1'b1;
                    for (int i = 0; i < HASH_WORDS - 1; i++) begin
                        v_next[i] = v_reg[i+1];
                    end
                end
                if (cnt_reg == 7'(HASH_WORDS)) begin
                    cnt_next = 7'd0;
                    if (!fin_reg) begin
                        state_next = S_IDLE;
                    end else if (done_reg) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_PAD;
                    end
                end
            end
            S_OUT: begin
                if (rd_pend_reg) begin
                    rd_pend_next  = 1'b0;
                    m_tvalid_next = 1'b1;
                    m_data_next   = hword;
                    m_idx_next    = oidx_reg;
                    m_last_next   = (oidx_reg == HADDR_W'(HASH_WORDS - 1));
                    oidx_next     = oidx_reg + HADDR_W'(1);
                    if (oidx_reg == HADDR_W'(HASH_WORDS - 1)) begin
                        // back to the initial vector for the next message
                        state_next  = S_IDLE;
                        hvalid_next = '0;
                        count_next  = '0;
                        fin_next    = 1'b0;
                        done_next   = 1'b0;
                    end
                end else if (!m_tvalid_reg) begin
                    rd_pend_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            fin_reg      <= 1'b0;
            phase_reg    <= 1'b0;
            done_reg     <= 1'b0;
            tail_reg     <= 1'b0;
            hvalid_reg   <= '0;
            cnt_reg      <= '0;
            oidx_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            fin_reg      <= fin_next;
            phase_reg    <= phase_next;
            done_reg     <= done_next;
            tail_reg     <= tail_next;
            hvalid_reg   <= hvalid_next;
            cnt_reg      <= cnt_next;
            oidx_reg     <= oidx_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        acc_reg    <= acc_next;
        w_reg      <= w_next;
        v_reg      <= v_next;
        hsel_reg   <= hram_raddr;
        m_data_reg <= m_data_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
    end

    // message block words
    shs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(BLOCK_WORDS)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (bram_we),
        .waddr (bram_waddr),
        .wdata (bram_wdata),
        .raddr (bram_raddr),
        .rdata (bram_rdata)
    );

    // chaining words, unwritten entries read as the initial vector
    shs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(HASH_WORDS)
    ) u_hash_ram (
        .aclk  (aclk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .raddr (hram_raddr),
        .rdata (hram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = m_last_reg;

    // finish transaction always starts padding
    a_fin_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == S_PAD))
        else $error("finish did not start padding");

    // a full block always starts a compression
    a_block_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (fill == BLOCK_LAST)) |=> (state_reg == S_LOAD))
        else $error("full block not compressed");

    // the hash ram is written only while folding
    a_hash_write: assert property (@(posedge aclk) disable iff (!aresetn)
        hram_we |-> (state_reg == S_FOLD))
        else $error("hash ram written outside fold");

    // last digest word restores the initial vector and clears the count
    a_digest_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_OUT) && rd_pend_reg && (oidx_reg == HADDR_W'(HASH_WORDS - 1)))
        |=> ((hvalid_reg == '0) && (count_reg == '0) && m_tlast))
        else $error("digest end did not restore state");

endmodule

// ===== hdl/shs_ram.sv =====
// generic simple dual-port ram with registered read
module shs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
